// ===== hw/rtl/crc32_msb_first_stream_defines.svh =====
// assertion macros used by the crc32 checker module
`ifndef CRC32_MSB_FIRST_STREAM_DEFINES_SVH
`define CRC32_MSB_FIRST_STREAM_DEFINES_SVH

// clocked check, ignored while reset is asserted
`define CRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define CRC_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/crc32_pkg.sv =====
// constants and table function for the msb-first crc32 stream
`timescale 1ns / 1ps
`default_nettype none

package crc32_pkg;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_TOP  = 32'h8000_0000;
	localparam int unsigned CNT_W    = 3;
	localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;

	// msb-first table entry for one top byte, eight shift steps
	function automatic logic [31:0] crc_entry(input logic [7:0] idx);
		logic [31:0] acc;
		acc = {idx, 24'h0};
		for (int k = 0; k < 8; k++) begin
			if ((acc & CRC_TOP) != 32'h0) begin
				acc = {acc[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				acc = {acc[30:0], 1'b0};
			end
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc32_msb_first_stream.sv =====
// Streaming CRC-32, polynomial 04C11DB7, msb first, one byte per word.
//
// Input channel s_*: one message byte per word, s_tlast on the final byte.
// Output channel m_*: one 32-bit checksum word per message, after its last byte.
// The first four bytes are packed big-endian and inverted after the fourth;
// later bytes go through a table step. Messages of four bytes or fewer yield
// the packed bytes, zero-padded at the low end.
// Path: the last byte is accepted into the input register, then its checksum
// into the result register. Throughput: one byte per cycle while s_tready is
// high; the crc update is one table lookup and xor on the registered byte.
// Reset clears the running register, the byte count and both valid flags.
// When m_tready stays low with a checksum waiting, non-last bytes keep
// flowing; a last byte then waits in the input register, and s_tready drops
// only once that register is held.
`timescale 1ns / 1ps
`default_nettype none

module crc32_msb_first_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // crc_value [31:0]
);

	logic                        valid_s1;
	logic [7:0]                  data_s1;
	logic                        last_s1;
	logic [31:0]                 crc_q;
	logic [crc32_pkg::CNT_W-1:0] cnt_q;
	logic                        out_valid_q;
	logic [31:0]                 out_data_q;

	logic                        out_free;
	logic                        advance;
	logic [31:0]                 crc_next;
	logic [crc32_pkg::CNT_W-1:0] cnt_next;
	logic [31:0]                 packed_word;
	logic [31:0]                 result;

	assign out_free = !out_valid_q || m_tready;
	// a non-last word never needs the result register
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    packed_word = crc_q | {data_s1, 24'h0};
			2'd1:    packed_word = crc_q | {8'h0, data_s1, 16'h0};
			2'd2:    packed_word = crc_q | {16'h0, data_s1, 8'h0};
			default: packed_word = crc_q | {24'h0, data_s1};
		endcase

		if (cnt_q < crc32_pkg::CNT_FULL) begin
			cnt_next = cnt_q + 1'b1;
			crc_next = (cnt_next == crc32_pkg::CNT_FULL) ? ~packed_word : packed_word;
		end else begin
			cnt_next = crc32_pkg::CNT_FULL;
			crc_next = {crc_q[23:0], data_s1} ^ crc32_pkg::crc_entry(crc_q[31:24]);
		end

		result = (cnt_next < crc32_pkg::CNT_FULL) ? crc_next : ~crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 32'h0;
			cnt_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				crc_q <= 32'h0;
				cnt_q <= '0;
			end else begin
				crc_q <= crc_next;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && last_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/crc32_chk.sv =====
// port-level checks for the crc32 stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "crc32_msb_first_stream_defines.svh"

module crc32_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	`CRC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "checksum word dropped")
	`CRC_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "checksum changed while stalled")
	// with the result side empty the input side never blocks
	`CRC_ASSERT(a_in_open, !m_tvalid |-> s_tready, "input stalled with output empty")
	`CRC_ASSERT_RST(a_rst_quiet, !arst_n |-> !m_tvalid, "checksum valid during reset")

endmodule

bind crc32_msb_first_stream crc32_chk u_chk (.*);

`default_nettype wire
